@@ hdl/lpr_pkg.sv @@
// Shared types, constants and helpers for the LRU page replacement unit.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int FRAME_COUNT_DEF = 16;
    localparam int PAGE_BITS_DEF   = 16;

    localparam int CFG_W       = 5;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

    // Tag carried from the front end to the back end with each item
    typedef struct packed {
        logic               skipped;
        logic [COUNT_W-1:0] ref_total;
    } lpr_tag_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ hdl/lpr_front.sv @@
// Front end: accepts references, flags repeats of the previous page and
// keeps the running reference count. Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_front #(
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PAGE_BITS-1:0] s_page_number,
    output logic                 push,
    input  logic                 q_ready,
    output lpr_pkg::lpr_tag_t    push_tag,
    output logic [PAGE_BITS-1:0] push_page
);

    logic [PAGE_BITS-1:0]          prev_page_reg;
    logic                          have_prev_reg;
    logic [lpr_pkg::COUNT_W-1:0]   ref_cnt_reg;
    logic [lpr_pkg::COUNT_W-1:0]   ref_cnt_next;

    assign s_ready      = q_ready;
    assign push         = s_valid && q_ready;
    assign ref_cnt_next = lpr_pkg::sat_inc(ref_cnt_reg);

    assign push_tag.skipped   = have_prev_reg && (s_page_number == prev_page_reg);
    assign push_tag.ref_total = ref_cnt_next;
    assign push_page          = s_page_number;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_page_reg <= '0;
            have_prev_reg <= 1'b0;
            ref_cnt_reg   <= '0;
        end else if (push) begin
            prev_page_reg <= s_page_number;
            have_prev_reg <= 1'b1;
            ref_cnt_reg   <= ref_cnt_next;
        end
    end

endmodule

@@ hdl/lpr_queue.sv @@
// Short register FIFO between the front and back ends.
// Depends on lpr_pkg for its depth.
`timescale 1ns / 1ps

module lpr_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              q_ready,
    input  logic [DATA_W-1:0] wdata,
    output logic              q_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = lpr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

@@ hdl/lpr_back.sv @@
// Back end: frame table lookup, LRU rank update, hit/fault/unique counts
// and the result register. Holds the frames_in_use register. Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_back #(
    parameter int FRAME_COUNT = lpr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]         cfg_frames_in_use,
    input  logic                              q_valid,
    output logic                              pop,
    input  lpr_pkg::lpr_tag_t                 q_tag,
    input  logic [PAGE_BITS-1:0]              q_page,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_skipped,
    output logic                              m_hit,
    output logic [lpr_pkg::SLOT_OUT_W-1:0]    m_slot,
    output logic                              m_evicted_valid,
    output logic [PAGE_BITS-1:0]              m_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]       m_hit_total,
    output logic [lpr_pkg::COUNT_W-1:0]       m_fault_total,
    output logic [lpr_pkg::COUNT_W-1:0]       m_unique_total,
    output logic [lpr_pkg::COUNT_W-1:0]       m_reference_total
);

    localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int ACT_W   = $clog2(FRAME_COUNT + 1);
    localparam int CNT_W   = lpr_pkg::COUNT_W;
    localparam int SOUT_W  = lpr_pkg::SLOT_OUT_W;

    logic [lpr_pkg::CFG_W-1:0] frames_cfg_reg;

    logic [PAGE_BITS-1:0] frame_page_reg [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] frame_valid_reg;
    logic [FRAME_COUNT-1:0] frame_valid_next;
    logic [IDX_W-1:0]     rank_reg  [FRAME_COUNT];
    logic [IDX_W-1:0]     rank_next [FRAME_COUNT];

    logic [CNT_W-1:0] hit_cnt_reg, fault_cnt_reg, unique_cnt_reg;

    logic [ACT_W-1:0]       act_num;
    logic [FRAME_COUNT-1:0] active;
    logic [FRAME_COUNT-1:0] match;
    logic [FRAME_COUNT-1:0] empty;
    logic [FRAME_COUNT-1:0] is_lru;
    logic                   hit_any, empty_any;
    logic [IDX_W-1:0]       hit_idx, empty_idx, lru_idx, slot_idx;
    logic                   skip, do_hit, do_fill, do_evict;
    logic [IDX_W-1:0]       sel_rank;
    logic [IDX_W+SOUT_W-1:0] slot_ext;

    logic                   m_valid_reg;
    logic                   m_skipped_reg, m_hit_reg, m_ev_valid_reg;
    logic [SOUT_W-1:0]      m_slot_reg;
    logic [PAGE_BITS-1:0]   m_ev_page_reg;
    logic [CNT_W-1:0]       m_hit_tot_reg, m_fault_tot_reg, m_uniq_tot_reg, m_ref_tot_reg;

    assign cfg_ready = 1'b1;
    assign pop       = q_valid && (!m_valid_reg || m_ready);
    assign skip      = q_tag.skipped;

    // Clamp the configured frame count to 1..FRAME_COUNT
    always_comb begin
        if (frames_cfg_reg == '0) begin
            act_num = ACT_W'(1);
        end else if (32'(frames_cfg_reg) > 32'(FRAME_COUNT)) begin
            act_num = ACT_W'(FRAME_COUNT);
        end else begin
            act_num = ACT_W'(frames_cfg_reg);
        end
    end

    always_comb begin
        for (int j = 0; j < FRAME_COUNT; j++) begin
            active[j] = (32'(j) < 32'(act_num));
            match[j]  = active[j] && frame_valid_reg[j] && (frame_page_reg[j] == q_page);
            empty[j]  = active[j] && !frame_valid_reg[j];
        end
    end

    // Oldest active frame: every other active frame ranks strictly newer
    always_comb begin
        for (int j = 0; j < FRAME_COUNT; j++) begin
            is_lru[j] = active[j];
            for (int k = 0; k < FRAME_COUNT; k++) begin
                if (k != j && active[k] && !(rank_reg[k] < rank_reg[j])) begin
                    is_lru[j] = 1'b0;
                end
            end
        end
    end

    // Lowest index wins in every encoder
    always_comb begin
        hit_any   = |match;
        empty_any = |empty;
        hit_idx   = '0;
        empty_idx = '0;
        lru_idx   = '0;
        for (int j = FRAME_COUNT - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit_idx = IDX_W'(j);
            end
            if (empty[j]) begin
                empty_idx = IDX_W'(j);
            end
            if (is_lru[j]) begin
                lru_idx = IDX_W'(j);
            end
        end
    end

    always_comb begin
        do_hit   = !skip && hit_any;
        do_fill  = !skip && !hit_any && empty_any;
        do_evict = !skip && !hit_any && !empty_any;
        if (skip) begin
            slot_idx = '0;
        end else if (hit_any) begin
            slot_idx = hit_idx;
        end else if (empty_any) begin
            slot_idx = empty_idx;
        end else begin
            slot_idx = lru_idx;
        end
        sel_rank = rank_reg[slot_idx];
        slot_ext = {{SOUT_W{1'b0}}, slot_idx};
    end

    // Promote the touched frame; age valid frames newer than it (all on a fill)
    always_comb begin
        frame_valid_next = frame_valid_reg;
        for (int j = 0; j < FRAME_COUNT; j++) begin
            rank_next[j] = rank_reg[j];
        end
        if (pop && !skip) begin
            frame_valid_next[slot_idx] = 1'b1;
            for (int j = 0; j < FRAME_COUNT; j++) begin
                if (IDX_W'(j) == slot_idx) begin
                    rank_next[j] = '0;
                end else if (frame_valid_reg[j] && (do_fill || rank_reg[j] < sel_rank)) begin
                    rank_next[j] = rank_reg[j] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !skip && !hit_any) begin
            frame_page_reg[slot_idx] <= q_page;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_cfg_reg  <= lpr_pkg::FRAMES_RESET;
            frame_valid_reg <= '0;
            for (int j = 0; j < FRAME_COUNT; j++) begin
                rank_reg[j] <= '0;
            end
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            unique_cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                frames_cfg_reg <= cfg_frames_in_use;
            end
            frame_valid_reg <= frame_valid_next;
            for (int j = 0; j < FRAME_COUNT; j++) begin
                rank_reg[j] <= rank_next[j];
            end
            if (pop && !skip) begin
                unique_cnt_reg <= lpr_pkg::sat_inc(unique_cnt_reg);
                if (do_hit) begin
                    hit_cnt_reg <= lpr_pkg::sat_inc(hit_cnt_reg);
                end else begin
                    fault_cnt_reg <= lpr_pkg::sat_inc(fault_cnt_reg);
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_skipped_reg   <= skip;
            m_hit_reg       <= do_hit;
            m_slot_reg      <= slot_ext[SOUT_W-1:0];
            m_ev_valid_reg  <= do_evict;
            m_ev_page_reg   <= do_evict ? frame_page_reg[slot_idx] : '0;
            m_hit_tot_reg   <= do_hit ? lpr_pkg::sat_inc(hit_cnt_reg) : hit_cnt_reg;
            m_fault_tot_reg <= (do_fill || do_evict) ? lpr_pkg::sat_inc(fault_cnt_reg)
                                                     : fault_cnt_reg;
            m_uniq_tot_reg  <= skip ? unique_cnt_reg : lpr_pkg::sat_inc(unique_cnt_reg);
            m_ref_tot_reg   <= q_tag.ref_total;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_skipped         = m_skipped_reg;
    assign m_hit             = m_hit_reg;
    assign m_slot            = m_slot_reg;
    assign m_evicted_valid   = m_ev_valid_reg;
    assign m_evicted_page    = m_ev_page_reg;
    assign m_hit_total       = m_hit_tot_reg;
    assign m_fault_total     = m_fault_tot_reg;
    assign m_unique_total    = m_uniq_tot_reg;
    assign m_reference_total = m_ref_tot_reg;

    a_hit_not_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_skipped_reg))
        else $error("result flags both hit and skip");

    a_evict_is_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ev_valid_reg) |-> (!m_hit_reg && !m_skipped_reg))
        else $error("eviction reported on a hit or skip");

    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((frame_valid_reg & $past(frame_valid_reg)) == $past(frame_valid_reg)))
        else $error("frame valid bit cleared");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (unique_cnt_reg != {CNT_W{1'b1}}) |->
        ((CNT_W+1)'(hit_cnt_reg) + (CNT_W+1)'(fault_cnt_reg) == (CNT_W+1)'(unique_cnt_reg)))
        else $error("hit and fault counts do not add up to unique count");

endmodule

@@ hdl/lru_page_replacement_unit.sv @@
// LRU page replacement unit: front end, item queue and back end.
// An accepted item passes through a queue entry, then the result register, before result valid.
// Throughput: one item per cycle while m_ready holds; set by the back end's lookup and rank update.
// Reset (aresetn, synchronous, active low): frames empty, counts zero, frames_in_use 16.
// No clearing pass; the unit accepts items as soon as reset is released.
`timescale 1ns / 1ps

module lru_page_replacement_unit #(
    parameter int FRAME_COUNT = lpr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]         cfg_frames_in_use,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PAGE_BITS-1:0]              s_page_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_skipped,
    output logic                              m_hit,
    output logic [lpr_pkg::SLOT_OUT_W-1:0]    m_slot,
    output logic                              m_evicted_valid,
    output logic [PAGE_BITS-1:0]              m_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]       m_hit_total,
    output logic [lpr_pkg::COUNT_W-1:0]       m_fault_total,
    output logic [lpr_pkg::COUNT_W-1:0]       m_unique_total,
    output logic [lpr_pkg::COUNT_W-1:0]       m_reference_total
);

    localparam int TAG_W  = $bits(lpr_pkg::lpr_tag_t);
    localparam int DATA_W = TAG_W + PAGE_BITS;

    logic                 push, q_ready, q_valid, pop;
    lpr_pkg::lpr_tag_t    push_tag, q_tag;
    logic [PAGE_BITS-1:0] push_page, q_page;
    logic [DATA_W-1:0]    q_wdata, q_rdata;

    assign q_wdata = {push_tag, push_page};
    assign q_tag   = lpr_pkg::lpr_tag_t'(q_rdata[DATA_W-1:PAGE_BITS]);
    assign q_page  = q_rdata[PAGE_BITS-1:0];

    lpr_front #(
        .PAGE_BITS(PAGE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_page_number (s_page_number),
        .push          (push),
        .q_ready       (q_ready),
        .push_tag      (push_tag),
        .push_page     (push_page)
    );

    lpr_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .q_ready (q_ready),
        .wdata   (q_wdata),
        .q_valid (q_valid),
        .pop     (pop),
        .rdata   (q_rdata)
    );

    lpr_back #(
        .FRAME_COUNT(FRAME_COUNT),
        .PAGE_BITS  (PAGE_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_frames_in_use (cfg_frames_in_use),
        .q_valid           (q_valid),
        .pop               (pop),
        .q_tag             (q_tag),
        .q_page            (q_page),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_skipped         (m_skipped),
        .m_hit             (m_hit),
        .m_slot            (m_slot),
        .m_evicted_valid   (m_evicted_valid),
        .m_evicted_page    (m_evicted_page),
        .m_hit_total       (m_hit_total),
        .m_fault_total     (m_fault_total),
        .m_unique_total    (m_unique_total),
        .m_reference_total (m_reference_total)
    );

endmodule

@@ tb/sv/lru_page_replacement_monitor.sv @@
// Monitor for the LRU page replacement unit: follows the frame-count writes and
// the page and result channels, predicts each result and compares it field by field.
// Depends on lpr_pkg for widths and the reset frame count.
`timescale 1ns / 1ps

module lru_page_replacement_monitor #(
    parameter int FRAMES = 16,
    parameter int PAGE_W = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]     cfg_frames_in_use,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [PAGE_W-1:0]             s_page_number,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_skipped,
    input  logic                          m_hit,
    input  logic [lpr_pkg::SLOT_OUT_W-1:0] m_slot,
    input  logic                          m_evicted_valid,
    input  logic [PAGE_W-1:0]             m_evicted_page,
    input  logic [lpr_pkg::COUNT_W-1:0]   m_hit_total,
    input  logic [lpr_pkg::COUNT_W-1:0]   m_fault_total,
    input  logic [lpr_pkg::COUNT_W-1:0]   m_unique_total,
    input  logic [lpr_pkg::COUNT_W-1:0]   m_reference_total,
    output int                            fail_count,
    output int                            pending
);

    localparam int SLOT_W  = lpr_pkg::SLOT_OUT_W;
    localparam int COUNT_W = lpr_pkg::COUNT_W;
    localparam int AGE_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef struct packed {
        logic               skipped;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] fault_total;
        logic [COUNT_W-1:0] unique_total;
        logic [COUNT_W-1:0] reference_total;
    } page_outcome_t;

    logic [PAGE_W-1:0]         frame_page [FRAMES];
    logic                      frame_used [FRAMES];
    logic [AGE_W-1:0]          frame_age  [FRAMES];
    logic [PAGE_W-1:0]         last_ref;
    logic                      seen_ref;
    logic [COUNT_W-1:0]        hits, faults, uniques, refs;
    logic [lpr_pkg::CFG_W-1:0] frames_setting;

    page_outcome_t outcomes [$];
    int            mismatches = 0;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Make frame s the newest; on a fill every other valid frame ages.
    function automatic void make_newest(input int s, input bit age_all);
        logic [AGE_W-1:0] lim;
        lim = frame_age[s];
        for (int j = 0; j < FRAMES; j++)
            if (frame_used[j] && j != s && (age_all || frame_age[j] < lim))
                frame_age[j] = frame_age[j] + 1'b1;
        frame_age[s] = '0;
    endfunction

    function automatic page_outcome_t replace_page(input logic [PAGE_W-1:0] page);
        page_outcome_t    o;
        int               active;
        int               s;
        bit               found;
        logic [AGE_W-1:0] oldest;
        o = '0;
        if (frames_setting == 0)
            active = 1;
        else if (frames_setting > FRAMES)
            active = FRAMES;
        else
            active = int'(frames_setting);

        refs      = bump(refs);
        o.skipped = seen_ref && (page == last_ref);
        last_ref  = page;
        seen_ref  = 1'b1;

        if (!o.skipped) begin
            uniques = bump(uniques);
            found   = 0;
            s       = 0;
            // lowest-index match wins when a page sits in two active frames
            for (int j = 0; j < active; j++)
                if (!found && frame_used[j] && frame_page[j] == page) begin
                    found = 1;
                    s     = j;
                end
            if (found) begin
                o.hit = 1'b1;
                hits  = bump(hits);
                make_newest(s, 1'b0);
            end else begin
                faults = bump(faults);
                for (int j = 0; j < active; j++)
                    if (!found && !frame_used[j]) begin
                        found = 1;
                        s     = j;
                    end
                if (found) begin
                    frame_used[s] = 1'b1;
                    frame_page[s] = page;
                    make_newest(s, 1'b1);
                end else begin
                    oldest = '0;
                    s      = 0;
                    for (int j = 0; j < active; j++)
                        if (frame_age[j] > oldest) begin
                            oldest = frame_age[j];
                            s      = j;
                        end
                    o.evicted_valid = 1'b1;
                    o.evicted_page  = frame_page[s];
                    frame_page[s]   = page;
                    make_newest(s, 1'b0);
                end
            end
            o.slot = SLOT_W'(s);
        end

        o.hit_total       = hits;
        o.fault_total     = faults;
        o.unique_total    = uniques;
        o.reference_total = refs;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        page_outcome_t want;
        if (!aresetn) begin
            for (int j = 0; j < FRAMES; j++) begin
                frame_page[j] = '0;
                frame_used[j] = 1'b0;
                frame_age[j]  = '0;
            end
            last_ref       = '0;
            seen_ref       = 1'b0;
            hits           = '0;
            faults         = '0;
            uniques        = '0;
            refs           = '0;
            frames_setting = lpr_pkg::FRAMES_RESET;
            outcomes.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                frames_setting = cfg_frames_in_use;
            if (s_valid && s_ready)
                outcomes.push_back(replace_page(s_page_number));
            if (m_valid && m_ready) begin
                if (outcomes.size() == 0) begin
                    $error("result item arrived with no page reference outstanding");
                    mismatches++;
                end else begin
                    want = outcomes.pop_front();
                    check_field("skipped", want.skipped, m_skipped);
                    check_field("hit", want.hit, m_hit);
                    check_field("slot", want.slot, m_slot);
                    check_field("evicted_valid", want.evicted_valid, m_evicted_valid);
                    check_field("evicted_page", want.evicted_page, m_evicted_page);
                    check_field("hit_total", want.hit_total, m_hit_total);
                    check_field("fault_total", want.fault_total, m_fault_total);
                    check_field("unique_total", want.unique_total, m_unique_total);
                    check_field("reference_total", want.reference_total, m_reference_total);
                end
            end
        end
        fail_count <= mismatches;
        pending    <= outcomes.size();
    end

endmodule

@@ tb/sv/lru_page_replacement_unit_test.sv @@
// Top of the LRU page replacement testbench: clock, reset, page references,
// frame-count writes and result back-pressure, plus the final verdict.
// Depends on lpr_pkg, lru_page_replacement_unit and lru_page_replacement_monitor.
`timescale 1ns / 1ps

module lru_page_replacement_unit_test;

    localparam int FRAMES      = 16;
    localparam int PAGE_W      = 16;
    localparam int ITEM_TARGET = 1900;
    localparam int POOL_MAX    = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic                          aclk              = 1'b0;
    logic                          aresetn           = 1'b0;
    logic                          cfg_valid         = 1'b0;
    logic [lpr_pkg::CFG_W-1:0]     cfg_frames_in_use = lpr_pkg::FRAMES_RESET;
    logic                          s_valid           = 1'b0;
    logic [PAGE_W-1:0]             s_page_number     = '0;
    logic                          m_ready           = 1'b0;
    logic                          cfg_ready;
    logic                          s_ready;
    logic                          m_valid;
    logic                          m_skipped;
    logic                          m_hit;
    logic [lpr_pkg::SLOT_OUT_W-1:0] m_slot;
    logic                          m_evicted_valid;
    logic [PAGE_W-1:0]             m_evicted_page;
    logic [lpr_pkg::COUNT_W-1:0]   m_hit_total;
    logic [lpr_pkg::COUNT_W-1:0]   m_fault_total;
    logic [lpr_pkg::COUNT_W-1:0]   m_unique_total;
    logic [lpr_pkg::COUNT_W-1:0]   m_reference_total;

    int fail_count;
    int pending;
    int cycles     = 0;
    int items_sent = 0;

    logic [PAGE_W-1:0] page_pool [POOL_MAX];
    logic [PAGE_W-1:0] last_sent = '0;
    logic [15:0]       ready_pattern = 16'hFFFF;
    logic [5:0]        ready_phase   = '0;

    lru_page_replacement_unit #(
        .FRAME_COUNT(FRAMES),
        .PAGE_BITS  (PAGE_W)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_frames_in_use(cfg_frames_in_use),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_page_number    (s_page_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_skipped        (m_skipped),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_evicted_valid  (m_evicted_valid),
        .m_evicted_page   (m_evicted_page),
        .m_hit_total      (m_hit_total),
        .m_fault_total    (m_fault_total),
        .m_unique_total   (m_unique_total),
        .m_reference_total(m_reference_total)
    );

    lru_page_replacement_monitor #(
        .FRAMES(FRAMES),
        .PAGE_W(PAGE_W)
    ) u_monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_frames_in_use(cfg_frames_in_use),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_page_number    (s_page_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_skipped        (m_skipped),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_evicted_valid  (m_evicted_valid),
        .m_evicted_page   (m_evicted_page),
        .m_hit_total      (m_hit_total),
        .m_fault_total    (m_fault_total),
        .m_unique_total   (m_unique_total),
        .m_reference_total(m_reference_total),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: stall on a 16-bit ready mask that is redrawn each time the 6-bit phase wraps.
    always @(posedge aclk) begin
        if (ready_phase == 0) begin
            case ($urandom_range(3))
                0: ready_pattern <= 16'hFFFF;
                1: ready_pattern <= 16'($urandom) | 16'h0101;
                2: ready_pattern <= 16'($urandom & $urandom) | 16'h0101;
                default: ready_pattern <= 16'($urandom) | 16'h1111;
            endcase
        end
        ready_phase <= ready_phase + 1'b1;
        m_ready     <= ready_pattern[ready_phase[3:0]];
    end

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_page(input logic [PAGE_W-1:0] page);
        s_valid       <= 1'b1;
        s_page_number <= page;
        last_sent      = page;
        items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [lpr_pkg::CFG_W-1:0] frames);
        wait_for_results();
        cfg_valid         <= 1'b1;
        cfg_frames_in_use <= frames;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly pages from the working set, some repeats of the last one, some noise.
    function automatic logic [PAGE_W-1:0] pick_page(input int pool_size);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return last_sent;
        if (r < 85)
            return page_pool[$urandom_range(pool_size - 1)];
        return PAGE_W'($urandom);
    endfunction

    initial begin
        logic [lpr_pkg::CFG_W-1:0] frame_choices [8];
        logic [lpr_pkg::CFG_W-1:0] frames;
        int phase;
        int active;
        int pool_size;
        int remaining;
        int burst;
        bit no_gaps;

        frame_choices = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd8, 5'd3, 5'd2};
        for (int j = 0; j < POOL_MAX; j++)
            page_pool[j] = PAGE_W'($urandom);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Page zero first: it matches the cleared previous page but must not skip.
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0000);

        // Two frames active: evict out of frames 0 and 1 while 2 and 3 keep pages.
        write_frames(5'd2);
        send_page(16'h5555);
        send_page(16'h1234);
        send_page(16'h5555);

        // Zero acts as one frame.
        write_frames(5'd0);
        send_page(16'h0007);
        send_page(16'h0008);
        send_page(16'h0008);

        // Above the frame count acts as all frames; 5555 now sits in two frames.
        write_frames(5'd31);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h8001);
        send_page(16'h7FFE);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            frames = (phase < 8) ? frame_choices[phase] : lpr_pkg::CFG_W'($urandom_range(31));
            phase++;
            write_frames(frames);
            if (frames == 0)
                active = 1;
            else if (frames > FRAMES)
                active = FRAMES;
            else
                active = int'(frames);
            pool_size = $urandom_range(1, (active + 4 < POOL_MAX) ? active + 4 : POOL_MAX);
            repeat ($urandom_range(0, 4))
                page_pool[$urandom_range(POOL_MAX - 1)] = PAGE_W'($urandom);
            no_gaps   = ($urandom_range(3) == 0);
            remaining = $urandom_range(40, 160);
            while (remaining > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && remaining > 0) begin
                    send_page(pick_page(pool_size));
                    burst--;
                    remaining--;
                end
                if (!no_gaps)
                    pause_sender();
            end
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
